// ----- rtl/lss_pkg.sv -----
`default_nettype none
package lss_pkg;
  localparam int unsigned StateSize = 12;
  localparam int unsigned InputSize = 4;
  localparam int unsigned NumLanes = 4;
  localparam int unsigned IdxW = 4;
  localparam int unsigned DataW = 32;
  localparam int unsigned ProdW = 64;
  localparam int unsigned AccW = 72;
  localparam int unsigned FracBits = 16;
  localparam int unsigned TermCount = StateSize + InputSize;
  localparam int unsigned TermW = $clog2(TermCount + 1);
  localparam int unsigned RowW = $clog2(StateSize);
  localparam int unsigned GroupCount = (StateSize + NumLanes - 1) / NumLanes;
  localparam int unsigned GroupW = (GroupCount > 1) ? $clog2(GroupCount) : 1;
  localparam int unsigned ColW = $clog2(StateSize);
  localparam int unsigned InColW = (InputSize > 1) ? $clog2(InputSize) : 1;
  localparam int unsigned AAddrW = $clog2(GroupCount * StateSize);
  localparam int unsigned BAddrW = (GroupCount * InputSize > 1) ?
                                   $clog2(GroupCount * InputSize) : 1;

  localparam logic [1:0] REQ_LOAD_A = 2'd0;
  localparam logic [1:0] REQ_LOAD_B = 2'd1;
  localparam logic [1:0] REQ_LOAD_X = 2'd2;
  localparam logic [1:0] REQ_STEP   = 2'd3;

  typedef logic signed [DataW-1:0] word_t;
  typedef logic signed [AccW-1:0] acc_t;

  typedef struct packed {
    logic clear;
    logic enable;
  } lane_ctrl_t;

  function automatic word_t sat_word(input acc_t acc);
    acc_t s;
    s = acc >>> FracBits;
    if (s > acc_t'(32'sh7fffffff)) return word_t'(32'sh7fffffff);
    if (s < -acc_t'(64'sh80000000)) return word_t'(32'sh80000000);
    return s[DataW-1:0];
  endfunction
endpackage
`default_nettype wire

// ----- rtl/lss_if.sv -----
`default_nettype none
interface lss_in_if;
  logic valid;
  logic ready;
  logic [1:0] req_type;
  logic [3:0] row_index;
  logic [3:0] col_index;
  logic signed [31:0] load_value;
  logic signed [31:0] ctrl_0;
  logic signed [31:0] ctrl_1;
  logic signed [31:0] ctrl_2;
  logic signed [31:0] ctrl_3;
  modport source(output valid, req_type, row_index, col_index, load_value,
                 ctrl_0, ctrl_1, ctrl_2, ctrl_3, input ready);
  modport sink(input valid, req_type, row_index, col_index, load_value,
               ctrl_0, ctrl_1, ctrl_2, ctrl_3, output ready);
endinterface

interface lss_out_if;
  logic valid;
  logic ready;
  logic [3:0] out_index;
  logic signed [31:0] out_value;
  logic out_last;
  modport source(output valid, out_index, out_value, out_last, input ready);
  modport sink(input valid, out_index, out_value, out_last, output ready);
endinterface
`default_nettype wire

// ----- rtl/lss_lane.sv -----
`default_nettype none
module lss_lane (
  input  wire logic               clk,
  input  wire lss_pkg::lane_ctrl_t ctrl,
  input  wire lss_pkg::word_t     coef,
  input  wire lss_pkg::word_t     operand,
  output lss_pkg::acc_t           acc
);
  import lss_pkg::*;
  logic signed [ProdW-1:0] prod_r;
  logic clear_r, enable_r;
  acc_t acc_r;

  // product registered before accumulation
  always_ff @(posedge clk) begin
    prod_r   <= ProdW'(coef) * ProdW'(operand);
    clear_r  <= ctrl.clear;
    enable_r <= ctrl.enable;
    if (clear_r) begin
      acc_r <= '0;
    end else if (enable_r) begin
      acc_r <= acc_r + AccW'(prod_r);
    end
  end
  assign acc = acc_r;
endmodule
`default_nettype wire

// ----- rtl/linear_state_space_step_unit.sv -----
`default_nettype none
// State-space step unit: x = A*x + B*u in signed Q16.16. Load items write one
// entry of A, B or x and produce nothing. A step item produces StateSize
// items (index, value, last) in index order. Four lanes each own one row at
// a time; a group of four rows issues one memory read per term, then the read
// register, the multiply register and the accumulate register drain, and the
// saturated sums are stored. The groups run in turn; the StateSize outputs
// then follow in order, subject to output back-pressure. Each lane holds the
// rows of A and B that it owns. Loads are written when accepted. Sums are
// exact, floored by 2^16, then saturated.
module linear_state_space_step_unit (
  input wire logic clk,
  input wire logic rst_n,
  lss_in_if.sink   in_ch,
  lss_out_if.source out_ch
);
  import lss_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_r;
  logic [TermW-1:0] term_r;        // term being issued
  logic [TermW+1:0] tick_r;        // cycles within a group
  logic [GroupW-1:0] group_r;
  logic [RowW:0] emit_r;           // row being shown
  word_t x_r [StateSize];
  word_t nx_r [StateSize];
  word_t u_r [InputSize];
  word_t a_mem [NumLanes][GroupCount*StateSize];
  word_t b_mem [NumLanes][GroupCount*InputSize];
  word_t coef_r [NumLanes];
  word_t opnd_r [NumLanes];
  logic issue_r;
  acc_t acc [NumLanes];
  lane_ctrl_t lctrl;

  wire accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  // lane for a row is row mod lanes, slot is row / lanes
  wire [RowW-1:0] ld_row = in_ch.row_index[RowW-1:0];
  wire row_ok = in_ch.row_index < IdxW'(StateSize);
  wire [1:0] ld_lane = 2'(in_ch.row_index % NumLanes);
  wire [GroupW-1:0] ld_grp = GroupW'(in_ch.row_index / NumLanes);

  // memory addresses within a lane
  wire [AAddrW-1:0] a_wr_addr = AAddrW'(ld_grp * StateSize) +
                                AAddrW'(in_ch.col_index[ColW-1:0]);
  wire [BAddrW-1:0] b_wr_addr = BAddrW'(ld_grp * InputSize) +
                                BAddrW'(in_ch.col_index[InColW-1:0]);
  wire [InColW-1:0] u_sel = InColW'(term_r - TermW'(StateSize));
  wire [AAddrW-1:0] a_rd_addr = AAddrW'(group_r * StateSize) +
                                AAddrW'(term_r[ColW-1:0]);
  wire [BAddrW-1:0] b_rd_addr = BAddrW'(group_r * InputSize) + BAddrW'(u_sel);

  // memory writes and per-lane registered reads
  always_ff @(posedge clk) begin
    for (int l = 0; l < NumLanes; l++) begin
      if (accept && row_ok && ld_lane == 2'(l)) begin
        if (in_ch.req_type == REQ_LOAD_A && in_ch.col_index < IdxW'(StateSize))
          a_mem[l][a_wr_addr] <= in_ch.load_value;
        if (in_ch.req_type == REQ_LOAD_B && in_ch.col_index < IdxW'(InputSize))
          b_mem[l][b_wr_addr] <= in_ch.load_value;
      end
      if (term_r < TermW'(StateSize)) begin
        coef_r[l] <= a_mem[l][a_rd_addr];
        opnd_r[l] <= x_r[term_r[ColW-1:0]];
      end else begin
        coef_r[l] <= b_mem[l][b_rd_addr];
        opnd_r[l] <= u_r[u_sel];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      term_r  <= '0;
      tick_r  <= '0;
      group_r <= '0;
      emit_r  <= '0;
      issue_r <= 1'b0;
      for (int i = 0; i < StateSize; i++) x_r[i] <= '0;
    end else begin
      issue_r <= (state_r == ST_RUN) && (term_r < TermW'(TermCount));
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_ch.req_type == REQ_LOAD_X && row_ok) x_r[ld_row] <= in_ch.load_value;
            if (in_ch.req_type == REQ_STEP) begin
              u_r[0] <= in_ch.ctrl_0;
              if (InputSize > 1) u_r[InColW'(1 % InputSize)] <= in_ch.ctrl_1;
              if (InputSize > 2) u_r[InColW'(2 % InputSize)] <= in_ch.ctrl_2;
              if (InputSize > 3) u_r[InColW'(3 % InputSize)] <= in_ch.ctrl_3;
              state_r <= ST_RUN;
              term_r  <= '0;
              tick_r  <= '0;
              group_r <= '0;
            end
          end
        end
        ST_RUN: begin
          tick_r <= tick_r + 1'b1;
          if (term_r < TermW'(TermCount)) term_r <= term_r + 1'b1;
          // pipeline: read reg, lane mul reg, ctrl reg, acc
          if (tick_r == (TermW+2)'(TermCount + 3)) begin
            for (int l = 0; l < NumLanes; l++)
              if (group_r*NumLanes + l < StateSize)
                nx_r[RowW'(group_r*NumLanes + l)] <= sat_word(acc[l]);
            tick_r <= '0;
            term_r <= '0;
            if (group_r == GroupW'(GroupCount - 1)) begin
              state_r <= ST_EMIT;
              emit_r  <= '0;
            end else begin
              group_r <= group_r + 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (out_ch.ready) begin
            x_r[emit_r[RowW-1:0]] <= nx_r[emit_r[RowW-1:0]];
            if (emit_r == (RowW+1)'(StateSize - 1)) state_r <= ST_IDLE;
            else emit_r <= emit_r + 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // clear before the group's first product reaches the adder
  always_comb begin
    lctrl.clear  = (state_r == ST_RUN) && (tick_r == '0);
    lctrl.enable = issue_r;
  end

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    lss_lane u_lane (
      .clk(clk), .ctrl(lctrl), .coef(coef_r[g]), .operand(opnd_r[g]), .acc(acc[g])
    );
  end

  assign out_ch.valid     = (state_r == ST_EMIT);
  assign out_ch.out_index = IdxW'(emit_r);
  assign out_ch.out_value = nx_r[emit_r[RowW-1:0]];
  assign out_ch.out_last  = (emit_r == (RowW+1)'(StateSize - 1));

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.out_last) |=> (state_r == ST_IDLE))
    else $error("no idle after last");
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(state_r == ST_EMIT)) |-> (emit_r == '0)) else $error("emit start");
endmodule
`default_nettype wire
